>>> design/sse_pkg.sv
// Shared types and constants for the sortable stack engine.
`timescale 1ns / 1ps
`default_nettype none

package sse_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int WORD_W          = 32;
   localparam int COUNT_W         = 7;
   localparam int OP_W            = 2;
   localparam int STATUS_W        = 2;

   // Request codes
   localparam logic [OP_W-1:0] REQ_PUSH = 2'd0;
   localparam logic [OP_W-1:0] REQ_POP  = 2'd1;
   localparam logic [OP_W-1:0] REQ_SORT = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [WORD_W-1:0] pop_value;
      logic [COUNT_W-1:0]      entry_count;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } ctl_type;

endpackage

`default_nettype wire

>>> design/sse_req_if.sv
// Request channel interface: valid/ready handshake with operation and push value.
`timescale 1ns / 1ps
`default_nettype none

interface sse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sse_pkg::OP_W-1:0]             req_type;
   logic signed [sse_pkg::WORD_W-1:0]    push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

`default_nettype wire

>>> design/sse_rsp_if.sv
// Response channel interface: valid/ready handshake with status, popped value and count.
`timescale 1ns / 1ps
`default_nettype none

interface sse_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [sse_pkg::STATUS_W-1:0]         status;
   logic signed [sse_pkg::WORD_W-1:0]    pop_value;
   logic [sse_pkg::COUNT_W-1:0]          entry_count;

   modport source (output valid, output status, output pop_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input pop_value, input entry_count,
                   output ready);
endinterface

`default_nettype wire

>>> design/sse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module sse_ram #(
   parameter int WIDTH = sse_pkg::WORD_W,
   parameter int DEPTH = sse_pkg::STACK_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/sse_seq.sv
// Sequencer: push/pop handling and insertion sort over the RAM with one comparator.
`timescale 1ns / 1ps
`default_nettype none

module sse_seq #(
   parameter int DEPTH = sse_pkg::STACK_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [sse_pkg::OP_W-1:0]         req_type,
   input  wire logic signed [sse_pkg::WORD_W-1:0] push_value,
   output sse_pkg::ctl_type                      ctl,
   output sse_pkg::rsp_type                      result,
   output logic                                  mem_we,
   output logic [AW-1:0]                         mem_waddr,
   output logic [sse_pkg::WORD_W-1:0]            mem_wdata,
   output logic [AW-1:0]                         mem_raddr,
   input  wire logic [sse_pkg::WORD_W-1:0]       mem_rdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FINISH = 3'd1;
   localparam logic [2:0] S_POPRD  = 3'd2;
   localparam logic [2:0] S_LOAD   = 3'd3;
   localparam logic [2:0] S_HELD   = 3'd4;
   localparam logic [2:0] S_PROBE  = 3'd5;
   localparam logic [2:0] S_CMP    = 3'd6;
   localparam logic [2:0] S_NEXT   = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 i_ff, i_in;
   logic [AW-1:0]                 j_ff, j_in;
   logic [sse_pkg::WORD_W-1:0]    held_ff, held_in;
   logic [sse_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [sse_pkg::WORD_W-1:0]    pop_ff, pop_in;
   logic [CW-1:0]                 count_dec;
   logic                          moves_up;

   assign count_dec = count_ff - CW'(1);
   // shared comparator: probed entry greater than held value (signed)
   assign moves_up  = $signed(mem_rdata) > $signed(held_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      held_in   = held_ff;
      status_in = status_ff;
      pop_in    = pop_ff;
      mem_we    = 1'b0;
      mem_waddr = j_ff;
      mem_wdata = held_ff;
      mem_raddr = i_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = sse_pkg::ST_OK;
               pop_in    = '0;
               state_in  = S_FINISH;
               unique case (req_type)
                  sse_pkg::REQ_PUSH: begin
                     if (count_ff == CW'(DEPTH)) begin
                        status_in = sse_pkg::ST_OVERFLOW;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = push_value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  sse_pkg::REQ_POP: begin
                     if (count_ff == '0) begin
                        status_in = sse_pkg::ST_UNDERFLOW;
                        pop_in    = '1;
                     end else begin
                        count_in  = count_dec;
                        mem_raddr = count_dec[AW-1:0];
                        state_in  = S_POPRD;
                     end
                  end
                  sse_pkg::REQ_SORT: begin
                     if (count_ff >= CW'(2)) begin
                        i_in     = AW'(1);
                        state_in = S_LOAD;
                     end
                  end
                  default: begin
                     // unused code: no change, plain ok result
                  end
               endcase
            end
         end
         S_POPRD: begin
            pop_in   = mem_rdata;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         S_LOAD: begin
            mem_raddr = i_ff;
            state_in  = S_HELD;
         end
         S_HELD: begin
            held_in  = mem_rdata;
            j_in     = i_ff;
            state_in = S_PROBE;
         end
         S_PROBE: begin
            if (j_ff == '0) begin
               mem_we    = 1'b1;
               state_in  = S_NEXT;
            end else begin
               mem_raddr = j_ff - AW'(1);
               state_in  = S_CMP;
            end
         end
         S_CMP: begin
            mem_we = 1'b1;
            if (moves_up) begin
               mem_wdata = mem_rdata;
               j_in      = j_ff - AW'(1);
               state_in  = S_PROBE;
            end else begin
               state_in  = S_NEXT;
            end
         end
         S_NEXT: begin
            if (CW'(i_ff) + CW'(1) == count_ff) begin
               state_in = S_FINISH;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      held_ff   <= held_in;
      status_ff <= status_in;
      pop_ff    <= pop_in;
   end

   assign ctl.idle           = (state_ff == S_IDLE);
   assign ctl.done           = (state_ff == S_FINISH);
   assign result.status      = status_ff;
   assign result.pop_value   = pop_ff;
   assign result.entry_count = sse_pkg::COUNT_W'(count_ff);

endmodule

`default_nettype wire

>>> design/sortable_stack_engine_core.sv
// Sortable stack engine top level: request handshake, sequencer, entry RAM, response register.
// Push, unused code and underflowing pop: the result passes from the S_FINISH state into the
// response register. Pop of a stored entry also passes through S_POPRD (one RAM read). Sort
// of n entries runs the single compare-and-move loop over the RAM port, S_LOAD to S_NEXT per
// entry; reverse order is the worst case. The next request waits for the sequencer to be idle.
// Synchronous reset empties the stack and the response slot; RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sortable_stack_engine_core #(
   parameter int STACK_DEPTH = sse_pkg::STACK_DEPTH_DEF,
   localparam int AW         = $clog2(STACK_DEPTH)
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sse_req_if.sink    req_ch,
   sse_rsp_if.source  rsp_ch
);

   sse_pkg::ctl_type            seq_ctl;
   sse_pkg::rsp_type            seq_result;
   sse_pkg::rsp_type            rsp_data_ff, rsp_data_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        req_take;

   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [sse_pkg::WORD_W-1:0]  mem_wdata;
   logic [AW-1:0]               mem_raddr;
   logic [sse_pkg::WORD_W-1:0]  mem_rdata;

   // Take a request only with the sequencer idle and the response slot free, or
   // emptying this cycle; the slot then stays free until that request finishes.
   assign req_ch.ready = seq_ctl.idle && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take     = req_ch.valid && req_ch.ready;

   sse_seq #(
      .DEPTH (STACK_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (req_take),
      .req_type   (req_ch.req_type),
      .push_value (req_ch.push_value),
      .ctl        (seq_ctl),
      .result     (seq_result),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // entry store, index 0 is the bottom of the stack
   sse_ram #(
      .WIDTH (sse_pkg::WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // response register: loads on finish, clears when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_ctl.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_data_ff.status;
   assign rsp_ch.pop_value   = rsp_data_ff.pop_value;
   assign rsp_ch.entry_count = rsp_data_ff.entry_count;

   // a finishing request must never land on an unread response
   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      seq_ctl.done |-> !rsp_valid_ff)
      else $error("response overwritten before being taken");

   // a taken request leaves the sequencer busy in the cycle after it is taken
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !seq_ctl.idle)
      else $error("sequencer idle straight after taking a request");

   // underflow only on an empty stack, with the all-ones pop value
   a_underflow_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == sse_pkg::ST_UNDERFLOW) |->
         (rsp_ch.pop_value == '1 && rsp_ch.entry_count == '0))
      else $error("malformed underflow response");

endmodule

`default_nettype wire
